### design/ray_sphere_hit_distance_top_assert.svh
// Assertion macros for the checker module of the ray/sphere block.
// The clock is clk and the synchronous active-low reset is rst_n.
`ifndef RAY_SPHERE_HIT_DISTANCE_TOP_ASSERT_SVH
`define RAY_SPHERE_HIT_DISTANCE_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define RSH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition must never be seen.
`define RSH_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### design/rsh_pkg.sv
`default_nettype none

package rsh_pkg;

  // Fixed-point format and field widths.
  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int DIST_W        = 31;

  // Exact intermediate widths.
  localparam int OFS_W   = COORD_W + 1;
  localparam int A_W     = 64;
  localparam int H_W     = 66;
  localparam int HABS_W  = 65;
  localparam int K_W     = 67;
  localparam int KABS_W  = 66;
  localparam int PROD_W  = 2 * HABS_W;
  localparam int DISC_W  = 132;
  localparam int ROOT_W  = DISC_W / 2;
  localparam int NUM_W   = 67;
  localparam int LIMB_W  = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd3;

  // Pipeline depths.
  localparam int QUAD_LAT = 5;
  localparam int MUL_LAT  = 3;
  localparam int LATENCY  = QUAD_LAT + MUL_LAT + 1 + ROOT_W + 1 + (1 + DIST_W) + 1;

  // Quadratic coefficients and early flags.
  typedef struct packed {
    logic [DIST_W-1:0] lim;
    logic [A_W-1:0]    a;
    logic [HABS_W-1:0] h_abs;
    logic [KABS_W-1:0] k_abs;
    logic              hle0;
    logic              kneg;
    logic              near;
    logic              miss;
  } quad_out_t;

  // Travels beside the H*H product.
  typedef struct packed {
    logic [DIST_W-1:0] lim;
    logic [HABS_W-1:0] h_abs;
    logic              hle0;
    logic              kneg;
    logic              near;
    logic              miss;
  } mul_side_t;

  // Travels through the square root.
  typedef struct packed {
    logic [DIST_W-1:0] lim;
    logic [A_W-1:0]    a;
    logic [HABS_W-1:0] h_abs;
    logic              hle0;
    logic              near;
    logic              miss;
  } root_side_t;

  // Travels through the divider.
  typedef struct packed {
    logic [DIST_W-1:0] lim;
    logic              miss;
  } div_side_t;

endpackage

`default_nettype wire

### design/ray_sphere_hit_distance_top.sv
// Ray/sphere nearest hit distance, fully pipelined.
// Throughput: one request per cycle; busy is always low, the result cannot be stalled.
// Most of the depth comes from the 66-stage square root and the 32-stage divider.
// Synchronous reset clears all valid bits and loads center 0 and radius 1.0.
`default_nettype none

module ray_sphere_hit_distance_top
  import rsh_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [COORD_W-1:0]   in_ray_origin_x,
  input  logic [COORD_W-1:0]   in_ray_origin_y,
  input  logic [COORD_W-1:0]   in_ray_origin_z,
  input  logic [COORD_W-1:0]   in_ray_dir_x,
  input  logic [COORD_W-1:0]   in_ray_dir_y,
  input  logic [COORD_W-1:0]   in_ray_dir_z,
  input  logic [DIST_W-1:0]    in_max_distance,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [DIST_W-1:0]    out_hit_distance,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  localparam logic [DIST_W-1:0] RADIUS_ONE = DIST_W'(1) << FRAC_BITS;

  logic [COORD_W-1:0] center_x_r;
  logic [COORD_W-1:0] center_y_r;
  logic [COORD_W-1:0] center_z_r;
  logic [DIST_W-1:0]  sphere_radius_r;

  logic               req;
  logic               quad_v;
  quad_out_t          quad_q;
  mul_side_t          mside_in;
  mul_side_t          mside_out;
  logic               mv_hh;
  logic               mv_ak;
  logic [PROD_W-1:0]  hh;
  logic [PROD_W-1:0]  ak;
  logic [A_W-1:0]     a_out;

  logic [DISC_W-1:0]  disc_nxt;
  logic               disc_v_r;
  logic [DISC_W-1:0]  disc_r;
  root_side_t         rside_r;

  logic               sq_v;
  logic [ROOT_W-1:0]  root;
  root_side_t         rside_o;

  logic [NUM_W-1:0]   n_nxt;
  logic               n_v_r;
  logic [NUM_W-1:0]   n_r;
  logic [A_W-1:0]     den_r;
  div_side_t          dside_r;

  logic               dv;
  logic [DIST_W-1:0]  quot;
  logic               ovf;
  div_side_t          dside_o;
  logic               hit_nxt;

  logic               out_valid_r;
  logic               out_hit_r;
  logic [DIST_W-1:0]  out_hit_distance_r;

  // A new request can enter every cycle.
  assign busy = 1'b0;
  assign req  = start & ~busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r      <= '0;
      center_y_r      <= '0;
      center_z_r      <= '0;
      sphere_radius_r <= RADIUS_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X: center_x_r      <= cfg_data;
        CFG_CENTER_Y: center_y_r      <= cfg_data;
        CFG_CENTER_Z: center_z_r      <= cfg_data;
        CFG_RADIUS:   sphere_radius_r <= cfg_data[DIST_W-1:0];
      endcase
    end
  end

  // Quadratic coefficients.
  rsh_quad u_quad (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req),
    .origin    ({in_ray_origin_z, in_ray_origin_y, in_ray_origin_x}),
    .dir       ({in_ray_dir_z, in_ray_dir_y, in_ray_dir_x}),
    .center    ({center_z_r, center_y_r, center_x_r}),
    .radius    (sphere_radius_r),
    .max_dist  (in_max_distance),
    .out_valid (quad_v),
    .out_q     (quad_q)
  );

  always_comb begin
    mside_in.lim   = quad_q.lim;
    mside_in.h_abs = quad_q.h_abs;
    mside_in.hle0  = quad_q.hle0;
    mside_in.kneg  = quad_q.kneg;
    mside_in.near  = quad_q.near;
    mside_in.miss  = quad_q.miss;
  end

  // H squared and A times |K| in parallel.
  rsh_mul #(
    .WA     (HABS_W),
    .WB     (HABS_W),
    .SIDE_W ($bits(mul_side_t))
  ) u_mul_hh (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (quad_v),
    .op_a      (quad_q.h_abs),
    .op_b      (quad_q.h_abs),
    .side_in   (mside_in),
    .out_valid (mv_hh),
    .prod      (hh),
    .side_out  (mside_out)
  );

  rsh_mul #(
    .WA     (A_W),
    .WB     (KABS_W),
    .SIDE_W (A_W)
  ) u_mul_ak (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (quad_v),
    .op_a      (quad_q.a),
    .op_b      (quad_q.k_abs),
    .side_in   (quad_q.a),
    .out_valid (mv_ak),
    .prod      (ak),
    .side_out  (a_out)
  );

  // Discriminant; a negative value means a miss.
  assign disc_nxt = mside_out.kneg ? ({2'b00, hh} + {2'b00, ak})
                                   : ({2'b00, hh} - {2'b00, ak});

  always_ff @(posedge clk) begin
    disc_r        <= disc_nxt;
    rside_r.lim   <= mside_out.lim;
    rside_r.a     <= a_out;
    rside_r.h_abs <= mside_out.h_abs;
    rside_r.hle0  <= mside_out.hle0;
    rside_r.near  <= mside_out.near;
    rside_r.miss  <= mside_out.miss | disc_nxt[DISC_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disc_v_r <= 1'b0;
    end else begin
      disc_v_r <= mv_hh & mv_ak;
    end
  end

  // Integer square root of the discriminant.
  rsh_sqrt #(
    .RW     (ROOT_W),
    .SIDE_W ($bits(root_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (disc_v_r),
    .radicand  (disc_r),
    .side_in   (rside_r),
    .out_valid (sq_v),
    .root      (root),
    .side_out  (rside_o)
  );

  // Numerator of the nearest nonnegative root.
  always_comb begin
    if (rside_o.near) begin
      n_nxt = NUM_W'(rside_o.h_abs) - NUM_W'(root);
    end else if (rside_o.hle0) begin
      n_nxt = NUM_W'(rside_o.h_abs) + NUM_W'(root);
    end else begin
      n_nxt = NUM_W'(root) - NUM_W'(rside_o.h_abs);
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    den_r        <= rside_o.a;
    dside_r.lim  <= rside_o.lim;
    dside_r.miss <= rside_o.miss;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_v_r <= 1'b0;
    end else begin
      n_v_r <= sq_v;
    end
  end

  // t = n * 2^FRAC_BITS / A.
  rsh_div #(
    .FRAC_BITS (FRAC_BITS),
    .NW        (NUM_W),
    .AW        (A_W),
    .QW        (DIST_W),
    .SIDE_W    ($bits(div_side_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (n_v_r),
    .num       (n_r),
    .den       (den_r),
    .side_in   (dside_r),
    .out_valid (dv),
    .quot      (quot),
    .ovf       (ovf),
    .side_out  (dside_o)
  );

  // Final limit check and result register.
  assign hit_nxt = ~dside_o.miss & ~ovf & (quot <= dside_o.lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
    end else begin
      out_valid_r <= dv;
      out_hit_r   <= dv & hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_distance_r <= hit_nxt ? quot : '0;
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_distance = out_hit_distance_r;

endmodule

`default_nettype wire

### design/rsh_quad.sv
`default_nettype none

module rsh_quad
  import rsh_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [2:0][COORD_W-1:0] origin,
  input  logic [2:0][COORD_W-1:0] dir,
  input  logic [2:0][COORD_W-1:0] center,
  input  logic [DIST_W-1:0]       radius,
  input  logic [DIST_W-1:0]       max_dist,
  output logic                    out_valid,
  output quad_out_t               out_q
);

  logic [QUAD_LAT-1:0]        vld_r;
  logic [DIST_W-1:0]          lim_r [QUAD_LAT-1];
  logic signed [OFS_W-1:0]    ofs_r [3];
  logic signed [COORD_W-1:0]  dir_r [3];
  logic [DIST_W-1:0]          rad_r;
  logic [A_W-1:0]             dd_r [3];
  logic signed [OFS_W+COORD_W-1:0] dl_r [3];
  logic [H_W-1:0]             ll_r [3];
  logic [2*DIST_W-1:0]        rr_r;
  logic [A_W-1:0]             a3_r;
  logic signed [H_W-1:0]      h3_r;
  logic [H_W-1:0]             ll_sum_r;
  logic [2*DIST_W-1:0]        rr3_r;
  logic [K_W-1:0]             k_r;
  logic [A_W-1:0]             a4_r;
  logic signed [H_W-1:0]      h4_r;
  logic                       hneg;
  logic                       hzero;
  logic                       kneg;
  logic                       kzero;
  quad_out_t                  out_r;

  // Valid bits follow the data through all five stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QUAD_LAT-2:0], in_valid};
    end
  end

  // Stage 1: origin relative to the center.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ofs_r[i] <= OFS_W'($signed(origin[i])) - OFS_W'($signed(center[i]));
      dir_r[i] <= dir[i];
    end
    rad_r    <= radius;
    lim_r[0] <= max_dist;
  end

  // Stage 2: component products.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dd_r[i] <= A_W'(dir_r[i]) * A_W'(dir_r[i]);
      dl_r[i] <= (OFS_W + COORD_W)'(dir_r[i]) * (OFS_W + COORD_W)'(ofs_r[i]);
      ll_r[i] <= H_W'(ofs_r[i]) * H_W'(ofs_r[i]);
    end
    rr_r     <= (2 * DIST_W)'(rad_r) * (2 * DIST_W)'(rad_r);
    lim_r[1] <= lim_r[0];
  end

  // Stage 3: dot products.
  always_ff @(posedge clk) begin
    a3_r     <= dd_r[0] + dd_r[1] + dd_r[2];
    h3_r     <= H_W'(dl_r[0]) + H_W'(dl_r[1]) + H_W'(dl_r[2]);
    ll_sum_r <= ll_r[0] + ll_r[1] + ll_r[2];
    rr3_r    <= rr_r;
    lim_r[2] <= lim_r[1];
  end

  // Stage 4: constant term.
  always_ff @(posedge clk) begin
    k_r      <= {1'b0, ll_sum_r} - K_W'(rr3_r);
    a4_r     <= a3_r;
    h4_r     <= h3_r;
    lim_r[3] <= lim_r[2];
  end

  // Signs decide which root can be nonnegative.
  always_comb begin
    hneg  = h4_r[H_W-1];
    hzero = (h4_r == '0);
    kneg  = k_r[K_W-1];
    kzero = (k_r == '0);
  end

  // Stage 5: magnitudes and flags.
  always_ff @(posedge clk) begin
    out_r.lim   <= lim_r[3];
    out_r.a     <= a4_r;
    out_r.h_abs <= hneg ? HABS_W'(-h4_r) : HABS_W'(h4_r);
    out_r.k_abs <= kneg ? KABS_W'(-k_r) : KABS_W'(k_r);
    out_r.hle0  <= hneg | hzero;
    out_r.kneg  <= kneg;
    out_r.near  <= (hneg | hzero) & ~kneg;
    out_r.miss  <= (a4_r == '0) | ~(hneg | hzero | kneg | kzero);
  end

  assign out_valid = vld_r[QUAD_LAT-1];
  assign out_q     = out_r;

endmodule

`default_nettype wire

### design/rsh_mul.sv
`default_nettype none

module rsh_mul
  import rsh_pkg::*;
#(
  parameter int WA     = HABS_W,
  parameter int WB     = HABS_W,
  parameter int SIDE_W = 1
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [WA-1:0]     op_a,
  input  logic [WB-1:0]     op_b,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [WA+WB-1:0]  prod,
  output logic [SIDE_W-1:0] side_out
);

  localparam int NA    = (WA + LIMB_W - 1) / LIMB_W;
  localparam int NB    = (WB + LIMB_W - 1) / LIMB_W;
  localparam int ROW_W = LIMB_W * (NB + 1);
  localparam int SUM_W = LIMB_W * (NA + NB);

  logic [NA*LIMB_W-1:0]  a_pad;
  logic [NB*LIMB_W-1:0]  b_pad;
  logic [2*LIMB_W-1:0]   pp_nxt [NA][NB];
  logic [2*LIMB_W-1:0]   pp_r   [NA][NB];
  logic [ROW_W-1:0]      row_nxt [NA];
  logic [ROW_W-1:0]      row_r   [NA];
  logic [SUM_W-1:0]      sum_nxt;
  logic [WA+WB-1:0]      prod_r;
  logic [MUL_LAT-1:0]    vld_r;
  logic [SIDE_W-1:0]     side_r [MUL_LAT];

  assign a_pad = (NA * LIMB_W)'(op_a);
  assign b_pad = (NB * LIMB_W)'(op_b);

  // Limb by limb partial products.
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_nxt[i][j] = (2 * LIMB_W)'(a_pad[i*LIMB_W +: LIMB_W])
                     * (2 * LIMB_W)'(b_pad[j*LIMB_W +: LIMB_W]);
      end
    end
  end

  // Each row is one limb of a times all of b.
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (ROW_W'(pp_r[i][j]) << (LIMB_W * j));
      end
    end
  end

  // Rows are aligned and summed.
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      sum_nxt = sum_nxt + (SUM_W'(row_r[i]) << (LIMB_W * i));
    end
  end

  always_ff @(posedge clk) begin
    pp_r      <= pp_nxt;
    row_r     <= row_nxt;
    prod_r    <= sum_nxt[WA+WB-1:0];
    side_r[0] <= side_in;
    side_r[1] <= side_r[0];
    side_r[2] <= side_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[MUL_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[MUL_LAT-1];
  assign prod      = prod_r;
  assign side_out  = side_r[MUL_LAT-1];

endmodule

`default_nettype wire

### design/rsh_sqrt.sv
`default_nettype none

module rsh_sqrt
  import rsh_pkg::*;
#(
  parameter int RW     = ROOT_W,
  parameter int SIDE_W = 1
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   radicand,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [RW-1:0]     root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int XW = 2 * RW;
  localparam int TW = XW + 1;

  logic [RW-1:0]     vld_r;
  logic [XW-1:0]     x_r    [RW];
  logic [TW-1:0]     r_r    [RW];
  logic [SIDE_W-1:0] side_r [RW];

  // One stage per root bit, most significant first.
  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam logic [TW-1:0] BIT = TW'(1) << (2 * (RW - 1 - k));

    logic              v_in;
    logic [XW-1:0]     x_in;
    logic [TW-1:0]     r_in;
    logic [SIDE_W-1:0] s_in;
    logic [TW-1:0]     trial;
    logic              take;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign x_in = radicand;
      assign r_in = '0;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = vld_r[k-1];
      assign x_in = x_r[k-1];
      assign r_in = r_r[k-1];
      assign s_in = side_r[k-1];
    end

    // Subtract the trial square when it fits.
    assign trial = r_in + BIT;
    assign take  = (TW'(x_in) >= trial);

    always_ff @(posedge clk) begin
      x_r[k]    <= take ? XW'(TW'(x_in) - trial) : x_in;
      r_r[k]    <= take ? ((r_in >> 1) + BIT) : (r_in >> 1);
      side_r[k] <= s_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_in;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign root      = r_r[RW-1][RW-1:0];
  assign side_out  = side_r[RW-1];

endmodule

`default_nettype wire

### design/rsh_div.sv
`default_nettype none

module rsh_div
  import rsh_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int NW        = NUM_W,
  parameter int AW        = A_W,
  parameter int QW        = DIST_W,
  parameter int SIDE_W    = 1
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NW-1:0]     num,
  input  logic [AW-1:0]     den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QW-1:0]     quot,
  output logic              ovf,
  output logic [SIDE_W-1:0] side_out
);

  localparam int DW = (NW + FRAC_BITS > AW + QW) ? NW + FRAC_BITS : AW + QW;

  logic [DW-1:0]     scaled;
  logic              vld0_r;
  logic [DW-1:0]     rem0_r;
  logic [AW-1:0]     den0_r;
  logic              ovf0_r;
  logic [SIDE_W-1:0] side0_r;
  logic [QW-1:0]     vld_r;
  logic [DW-1:0]     rem_r  [QW];
  logic [QW-1:0]     q_r    [QW];
  logic [AW-1:0]     den_r  [QW-1];
  logic [QW-1:0]     ovf_r;
  logic [SIDE_W-1:0] side_r [QW];

  assign scaled = DW'(num) << FRAC_BITS;

  // Entry stage: scale the numerator and catch a quotient that is out of range.
  always_ff @(posedge clk) begin
    rem0_r  <= scaled;
    den0_r  <= den;
    ovf0_r  <= (scaled >= (DW'(den) << QW));
    side0_r <= side_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= in_valid;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int BIT_POS = QW - 1 - k;

    logic              v_in;
    logic [DW-1:0]     rem_in;
    logic [QW-1:0]     q_in;
    logic [AW-1:0]     den_in;
    logic              ovf_in;
    logic [SIDE_W-1:0] s_in;
    logic [DW-1:0]     shifted;
    logic              take;

    if (k == 0) begin : g_first
      assign v_in   = vld0_r;
      assign rem_in = rem0_r;
      assign q_in   = '0;
      assign den_in = den0_r;
      assign ovf_in = ovf0_r;
      assign s_in   = side0_r;
    end else begin : g_next
      assign v_in   = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
      assign ovf_in = ovf_r[k-1];
      assign s_in   = side_r[k-1];
    end

    assign shifted = DW'(den_in) << BIT_POS;
    assign take    = (rem_in >= shifted);

    always_ff @(posedge clk) begin
      rem_r[k]  <= take ? (rem_in - shifted) : rem_in;
      q_r[k]    <= q_in | (QW'(take) << BIT_POS);
      ovf_r[k]  <= ovf_in;
      side_r[k] <= s_in;
    end

    // The divisor is not needed after the last stage.
    if (k < QW - 1) begin : g_den
      always_ff @(posedge clk) begin
        den_r[k] <= den_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_in;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign quot      = q_r[QW-1];
  assign ovf       = ovf_r[QW-1];
  assign side_out  = side_r[QW-1];

endmodule

`default_nettype wire

### design/rsh_chk.sv
`default_nettype none

`include "ray_sphere_hit_distance_top_assert.svh"

module rsh_chk
  import rsh_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic [COORD_W-1:0]   in_ray_dir_x,
  input logic [COORD_W-1:0]   in_ray_dir_y,
  input logic [COORD_W-1:0]   in_ray_dir_z,
  input logic [DIST_W-1:0]    in_max_distance,
  input logic                 out_valid,
  input logic                 out_hit,
  input logic [DIST_W-1:0]    out_hit_distance
);

  // Every result goes back to an earlier accepted request.
  `RSH_ASSERT_IMP(a_latency, out_valid, $past(start && !busy, LATENCY), "result without request")

  // A miss reports a zero distance.
  `RSH_ASSERT_IMP(a_miss_zero, out_valid && !out_hit, out_hit_distance == '0, "miss with distance")

  // A hit never goes beyond the limit of its own request.
  `RSH_ASSERT_IMP(a_limit, out_valid && out_hit,
                  out_hit_distance <= $past(in_max_distance, LATENCY), "hit beyond limit")

  // A zero direction can never hit.
  `RSH_ASSERT_IMP(a_zero_dir,
                  out_valid && $past(start && !busy && in_ray_dir_x == '0 &&
                                     in_ray_dir_y == '0 && in_ray_dir_z == '0, LATENCY),
                  !out_hit, "hit with zero direction")

  // The hit flag stays low between results.
  `RSH_ASSERT_NEVER(a_hit_strobe, out_hit && !out_valid, "hit without strobe")

endmodule

bind ray_sphere_hit_distance_top rsh_chk u_rsh_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_ray_dir_x     (in_ray_dir_x),
  .in_ray_dir_y     (in_ray_dir_y),
  .in_ray_dir_z     (in_ray_dir_z),
  .in_max_distance  (in_max_distance),
  .out_valid        (out_valid),
  .out_hit          (out_hit),
  .out_hit_distance (out_hit_distance)
);

`default_nettype wire

### test/ray_sphere_hit_distance_checker.sv
`default_nettype none

module ray_sphere_hit_distance_checker
  import rsh_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic [COORD_W-1:0]   in_ray_origin_x,
  input  wire logic [COORD_W-1:0]   in_ray_origin_y,
  input  wire logic [COORD_W-1:0]   in_ray_origin_z,
  input  wire logic [COORD_W-1:0]   in_ray_dir_x,
  input  wire logic [COORD_W-1:0]   in_ray_dir_y,
  input  wire logic [COORD_W-1:0]   in_ray_dir_z,
  input  wire logic [DIST_W-1:0]    in_max_distance,
  input  wire logic                 out_valid,
  input  wire logic                 out_hit,
  input  wire logic [DIST_W-1:0]    out_hit_distance,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_W-1:0]   cfg_data,
  output int                        error_count,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [159:0] wide_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
  } hit_result_t;

  // Local copy of the sphere registers.
  logic [COORD_W-1:0] sph_cx, sph_cy, sph_cz;
  logic [DIST_W-1:0]  sph_r;

  hit_result_t hits_due_q[$];

  assign pending = hits_due_q.size();

  // Exact nearest-hit computation on 160-bit signed integers.
  function automatic hit_result_t nearest_hit(
    input logic [COORD_W-1:0] ox, oy, oz, dx, dy, dz,
    input logic [DIST_W-1:0]  lim
  );
    wide_t ddx, ddy, ddz, lx, ly, lz, rad;
    wide_t a2, h, k, disc, root, trial, num, quo;
    hit_result_t res;
    res = '0;
    ddx = $signed(dx);
    ddy = $signed(dy);
    ddz = $signed(dz);
    lx = $signed(ox) - $signed(sph_cx);
    ly = $signed(oy) - $signed(sph_cy);
    lz = $signed(oz) - $signed(sph_cz);
    rad = {129'b0, sph_r};
    a2 = ddx * ddx + ddy * ddy + ddz * ddz;
    if (a2 == 0) return res;
    h = ddx * lx + ddy * ly + ddz * lz;
    k = lx * lx + ly * ly + lz * lz - rad * rad;
    disc = h * h - a2 * k;
    if (disc < 0) return res;
    // Bitwise integer square root, floor.
    root = 0;
    for (int b = 66; b >= 0; b--) begin
      trial = root | (wide_t'(1) <<< b);
      if (trial * trial <= disc) root = trial;
    end
    // Near root when both roots are ahead, else the far root if it is ahead.
    if (h <= 0 && k >= 0) begin
      num = -h - root;
    end else if (h <= 0 || k <= 0) begin
      num = -h + root;
    end else begin
      return res;
    end
    quo = (num <<< FRAC_BITS_DEF) / a2;
    if (quo >= (wide_t'(1) <<< 31)) return res;
    if (quo > $signed({129'b0, lim})) return res;
    res.hit = 1'b1;
    res.distance = quo[DIST_W-1:0];
    return res;
  endfunction

  // Track register writes, predict accepted requests and check results.
  always @(posedge clk) begin
    hit_result_t want;
    if (!rst_n) begin
      sph_cx <= '0;
      sph_cy <= '0;
      sph_cz <= '0;
      sph_r  <= DIST_W'(65536);
      hits_due_q.delete();
      error_count <= 0;
    end else begin
      if (start && !busy) begin
        hits_due_q.push_back(nearest_hit(in_ray_origin_x, in_ray_origin_y, in_ray_origin_z,
                                         in_ray_dir_x, in_ray_dir_y, in_ray_dir_z,
                                         in_max_distance));
      end
      if (out_valid) begin
        if (hits_due_q.size() == 0) begin
          $display("%0t: unexpected result hit=%0b dist=%0d", $time, out_hit, out_hit_distance);
          error_count <= error_count + 1;
        end else begin
          want = hits_due_q.pop_front();
          if (want.hit !== out_hit || want.distance !== out_hit_distance) begin
            $display("%0t: mismatch expected hit=%0b dist=%0d, actual hit=%0b dist=%0d",
                     $time, want.hit, want.distance, out_hit, out_hit_distance);
            error_count <= error_count + 1;
          end
        end
      end
      // Register updates apply to requests accepted after this edge.
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER_X: sph_cx <= cfg_data;
          CFG_CENTER_Y: sph_cy <= cfg_data;
          CFG_CENTER_Z: sph_cz <= cfg_data;
          CFG_RADIUS:   sph_r  <= cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### test/ray_sphere_hit_distance_top_test.sv
`default_nettype none

module ray_sphere_hit_distance_top_test;
  import rsh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 65536;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [COORD_W-1:0]   in_ray_origin_x = '0;
  logic [COORD_W-1:0]   in_ray_origin_y = '0;
  logic [COORD_W-1:0]   in_ray_origin_z = '0;
  logic [COORD_W-1:0]   in_ray_dir_x = '0;
  logic [COORD_W-1:0]   in_ray_dir_y = '0;
  logic [COORD_W-1:0]   in_ray_dir_z = '0;
  logic [DIST_W-1:0]    in_max_distance = '0;
  logic                 out_valid;
  logic                 out_hit;
  logic [DIST_W-1:0]    out_hit_distance;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;
  int                   error_count;
  int                   pending;

  // Current sphere, kept here to aim rays at it.
  logic signed [COORD_W-1:0] cur_c [3];
  logic [DIST_W-1:0]         cur_r;

  always #6 clk = ~clk;

  ray_sphere_hit_distance_top uut (.*);

  ray_sphere_hit_distance_checker u_checker (.*);

  // Drive one request and hold it until accepted.
  task automatic send_ray(input logic [31:0] ox, oy, oz, dx, dy, dz,
                          input logic [30:0] lim, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_ray_origin_x <= ox;
    in_ray_origin_y <= oy;
    in_ray_origin_z <= oz;
    in_ray_dir_x <= dx;
    in_ray_dir_y <= dy;
    in_ray_dir_z <= dz;
    in_max_distance <= lim;
    do @(posedge clk); while (busy);
  endtask

  // Write the whole sphere once no request is in flight.
  task automatic set_sphere(input logic [31:0] cx, cy, cz, input logic [30:0] r);
    start <= 1'b0;
    // The wait lets the last accepted request reach the pending count.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cur_c[0] = cx;
    cur_c[1] = cy;
    cur_c[2] = cz;
    cur_r = r;
    cfg_we <= 1'b1;
    cfg_index <= CFG_CENTER_X; cfg_data <= cx; @(posedge clk);
    cfg_index <= CFG_CENTER_Y; cfg_data <= cy; @(posedge clk);
    cfg_index <= CFG_CENTER_Z; cfg_data <= cz; @(posedge clk);
    cfg_index <= CFG_RADIUS;   cfg_data <= {1'b0, r}; @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] scaled_rand();
    return $signed($urandom) >>> $urandom_range(31);
  endfunction

  // Mostly rays aimed near the sphere center, some pure noise.
  task automatic random_ray(input int idle_pct);
    logic [31:0] o [3];
    logic [31:0] d [3];
    logic [30:0] lim;
    int sh;
    sh = $urandom_range(31);
    if ($urandom_range(9) < 2) begin
      foreach (o[i]) o[i] = $urandom;
      foreach (d[i]) d[i] = $urandom;
    end else begin
      foreach (o[i]) o[i] = cur_c[i] + ($signed($urandom) >>> sh);
      foreach (d[i]) begin
        d[i] = (cur_c[i] - o[i]) + scaled_rand();
        if ($urandom_range(9) == 0) d[i] = '0;
        if ($urandom_range(4) == 0) d[i] = $signed(d[i]) >>> $urandom_range(16);
      end
    end
    case ($urandom_range(3))
      0: lim = 31'($urandom);
      1: lim = 31'($urandom >> $urandom_range(31));
      default: lim = '1;
    endcase
    send_ray(o[0], o[1], o[2], d[0], d[1], d[2], lim, idle_pct);
  endtask

  initial begin
    int idle_pct [4] = '{0, 81, 0, 33};
    cur_c = '{default: '0};
    cur_r = 31'(ONE);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases on the reset sphere of radius one at the origin.
    send_ray(0, 0, 0, 0, 0, 0, '1, 0);                     // zero direction
    send_ray(-2 * ONE, 3 * ONE, 0, ONE, 0, 0, '1, 0);      // clear miss
    send_ray(-2 * ONE, ONE, 0, ONE, 0, 0, '1, 0);          // tangent ray
    send_ray(ONE, 0, 0, ONE, 0, 0, '1, 0);                 // origin on surface, leaving
    send_ray(-ONE, 0, 0, ONE, 0, 0, '1, 0);                // origin on surface, entering
    send_ray(0, 0, 0, 0, ONE, 0, '1, 0);                   // inside the sphere
    send_ray(2 * ONE, 0, 0, ONE, 0, 0, '1, 0);             // both roots behind
    send_ray(-3 * ONE, 0, 0, ONE, 0, 0, '1, 0);            // normal hit at 2.0
    send_ray(-3 * ONE, 0, 0, ONE, 0, 0, 31'(2 * ONE), 0);      // hit exactly at limit
    send_ray(-3 * ONE, 0, 0, ONE, 0, 0, 31'(2 * ONE - 1), 0);  // hit beyond limit
    send_ray(-3 * ONE, 0, 0, ONE, 0, 0, '0, 0);            // zero limit
    send_ray(-30000 * ONE, 0, 0, 1, 0, 0, '1, 0);          // t out of range
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '1, 0);
    send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, 0);
    send_ray('1, '1, '1, '1, '1, '1, '1, 0);
    send_ray(0, 0, 0, 32'h8000_0000, 0, 0, '1, 0);

    // Random phases under several sphere settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_sphere(0, 0, 0, 31'(ONE));
        1: set_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, '1);
        2: set_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, '0);
        3: set_sphere(5 * ONE, -7 * ONE, 3 * ONE, 31'(2 * ONE));
        default: set_sphere($urandom, $urandom, $urandom,
                            31'($urandom >> $urandom_range(31)));
      endcase
      for (int n = 0; n < 215; n++) begin
        random_ray(idle_pct[ph % 4]);
        // One hold-off until everything in flight has drained.
        if (ph == 4 && n == 100) begin
          start <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("** ray_sphere_hit_distance_top: PASSED **");
    end else begin
      $display("** ray_sphere_hit_distance_top: FAILED **");
    end
    $finish;
  end

  // Watchdog for a stuck run.
  initial begin
    #5ms;
    $display("** ray_sphere_hit_distance_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
